// File: rtl/cat_pkg.sv
// types and codes shared by the cyclic alarm table
package cat_pkg;

	localparam int FIELD_W  = 16;
	localparam int REM_W    = 17;
	localparam int CNT_W    = 17;
	localparam int REQ_W    = 3;
	localparam int ID_W     = 8;
	localparam int ST_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [REQ_W-1:0] REQ_ARM_REL = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ARM_ABS = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CANCEL  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd4;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_BAD_ID    = 3'd1;
	localparam logic [ST_W-1:0] ST_BAD_VALUE = 3'd2;
	localparam logic [ST_W-1:0] ST_RUNNING   = 3'd3;
	localparam logic [ST_W-1:0] ST_STOPPED   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALLOWED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CYCLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT_CHECK   = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [ID_W-1:0]    alarm_id;
		logic [FIELD_W-1:0] amount;
		logic [FIELD_W-1:0] cycle;
		logic [FIELD_W-1:0] counter_now;
	} cat_req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [REM_W-1:0] remaining_ticks;
		logic [CNT_W-1:0] expiry_count;
		logic             alarm_running;
	} cat_res_t;

endpackage

// File: rtl/cyclic_alarm_table_core.sv
// cyclic alarm table: request sequencer, entry memory and shared divider
// arm relative, cancel, read, unknown, plain advance: decode state, then response state;
// an advance that expires a cyclic alarm adds the 17-step divider, an absolute arm adds
// two 17-step modulo passes; one request at a time until its response is registered
// a new request is taken while the previous response beat still waits
// reset clears running flags and handshake state, presets config; entry memory is not cleared
module cyclic_alarm_table_core
	import cat_pkg::*;
#(
	parameter int NUM_ALARMS = 32,
	parameter int TICK_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  cat_req_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output cat_res_t             rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	localparam int IdxW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
	localparam int CutW = (TICK_WIDTH < FIELD_W) ? TICK_WIDTH : FIELD_W;
	localparam logic [FIELD_W-1:0] CutMask = FIELD_W'((64'd1 << CutW) - 64'd1);
	localparam logic [ID_W:0] NumAlarms = (ID_W+1)'(NUM_ALARMS);
	localparam int EntW = REM_W + FIELD_W;
	localparam int StepW = $clog2(REM_W);
	localparam logic [StepW-1:0] LastStep = StepW'(REM_W - 1);

	typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DIV, S_FIN, S_OUT} state_t;
	typedef enum logic [1:0] {DIV_MOD_START, DIV_MOD_NOW, DIV_COUNT} div_op_t;

	state_t             state_q;
	div_op_t            div_op_q;
	logic [REQ_W-1:0]   type_q;
	logic [FIELD_W-1:0] amt_q;
	logic [FIELD_W-1:0] cyc_q;
	logic [FIELD_W-1:0] now_q;
	logic [IdxW-1:0]    idx_q;
	logic               id_ok_q;
	logic [NUM_ALARMS-1:0] run_q;
	logic [EntW-1:0]    tbl_mem [NUM_ALARMS];
	logic [EntW-1:0]    rd_q;
	logic [REM_W-1:0]   dv_rem_q;
	logic [REM_W-1:0]   dv_quo_q;
	logic [REM_W-1:0]   dv_dvs_q;
	logic [StepW-1:0]   step_q;
	logic [REM_W-1:0]   s_mod_q;
	cat_res_t           res_q;
	cat_res_t           rsp_q;
	logic               rsp_valid_q;
	logic [FIELD_W-1:0] max_q;
	logic [FIELD_W-1:0] min_q;
	logic               ext_q;

	logic [REM_W-1:0]   rd_rem;
	logic [FIELD_W-1:0] rd_cyc;
	logic [REM_W-1:0]   amt17;
	logic [REM_W-1:0]   span;
	logic               cur_run;
	logic               bad_val;
	logic               req_take;

	cat_res_t           ev_res;
	logic               ev_go_div;
	div_op_t            ev_op;
	logic [REM_W-1:0]   ev_dvd;
	logic [REM_W-1:0]   ev_dvs;
	logic               ev_we;
	logic [EntW-1:0]    ev_wd;
	logic               ev_set;
	logic               ev_clr;

	cat_res_t           fin_res;
	logic [EntW-1:0]    fin_wd;
	logic [REM_W-1:0]   abs_d;
	logic [REM_W-1:0]   cyc_left;

	logic [REM_W:0]     dv_sh;
	logic               dv_bit;
	logic [REM_W-1:0]   dv_rem_nx;

	logic               mem_we;
	logic [EntW-1:0]    mem_wd;

	assign req_ready = (state_q == S_IDLE);
	assign req_take  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rd_rem  = rd_q[EntW-1:FIELD_W];
	assign rd_cyc  = rd_q[FIELD_W-1:0];
	assign amt17   = {1'b0, amt_q};
	assign span    = {1'b0, max_q} + REM_W'(1);
	assign cur_run = run_q[idx_q];
	assign bad_val = ext_q && ((amt_q > max_q) ||
		((cyc_q != '0) && ((cyc_q > max_q) || (cyc_q < min_q))));

	// request decode on the entry read back
	always_comb begin
		ev_res.status          = ST_OK;
		ev_res.remaining_ticks = cur_run ? rd_rem : '0;
		ev_res.expiry_count    = '0;
		ev_res.alarm_running   = cur_run;
		ev_go_div = 1'b0;
		ev_op     = DIV_COUNT;
		ev_dvd    = '0;
		ev_dvs    = '0;
		ev_we     = 1'b0;
		ev_wd     = rd_q;
		ev_set    = 1'b0;
		ev_clr    = 1'b0;
		if (!id_ok_q) begin
			ev_res.status          = ST_BAD_ID;
			ev_res.remaining_ticks = '0;
			ev_res.alarm_running   = 1'b0;
		end else begin
			case (type_q) inside
				REQ_ARM_REL, REQ_ARM_ABS: begin
					if (bad_val) begin
						ev_res.status = ST_BAD_VALUE;
					end else if (cur_run) begin
						ev_res.status = ST_RUNNING;
					end else if (type_q == REQ_ARM_REL) begin
						ev_we  = 1'b1;
						ev_wd  = {amt17, cyc_q};
						ev_set = 1'b1;
						ev_res.remaining_ticks = amt17;
						ev_res.alarm_running   = 1'b1;
					end else begin
						ev_go_div = 1'b1;
						ev_op     = DIV_MOD_START;
						ev_dvd    = amt17;
						ev_dvs    = span;
					end
				end
				REQ_CANCEL: begin
					if (!cur_run) begin
						ev_res.status = ST_STOPPED;
					end else begin
						ev_clr = 1'b1;
						ev_res.remaining_ticks = '0;
						ev_res.alarm_running   = 1'b0;
					end
				end
				REQ_READ: begin
					if (!cur_run) begin
						ev_res.status = ST_STOPPED;
					end
				end
				REQ_ADVANCE: begin
					if (!cur_run) begin
						ev_res.status = ST_STOPPED;
					end else if (rd_rem > amt17) begin
						ev_we = 1'b1;
						ev_wd = {rd_rem - amt17, rd_cyc};
						ev_res.remaining_ticks = rd_rem - amt17;
					end else if (rd_cyc == '0) begin
						ev_clr = 1'b1;
						ev_res.remaining_ticks = '0;
						ev_res.expiry_count    = CNT_W'(1);
						ev_res.alarm_running   = 1'b0;
					end else begin
						ev_go_div = 1'b1;
						ev_op     = DIV_COUNT;
						ev_dvd    = amt17 - rd_rem;
						ev_dvs    = {1'b0, rd_cyc};
					end
				end
				default: begin
					ev_res.status = ST_BAD_VALUE;
				end
			endcase
		end
	end

	// restoring divider step
	always_comb begin
		dv_sh     = {dv_rem_q, dv_quo_q[REM_W-1]};
		dv_bit    = (dv_sh >= {1'b0, dv_dvs_q});
		dv_rem_nx = dv_bit ? REM_W'(dv_sh - {1'b0, dv_dvs_q}) : dv_sh[REM_W-1:0];
	end

	// finishing step after the divider
	always_comb begin
		abs_d    = (s_mod_q >= dv_rem_q) ? (s_mod_q - dv_rem_q) :
			(span - (dv_rem_q - s_mod_q));
		if (abs_d == '0) begin
			abs_d = span;
		end
		cyc_left = {1'b0, rd_cyc} - dv_rem_q;
		fin_res.status        = ST_OK;
		fin_res.alarm_running = 1'b1;
		if (div_op_q == DIV_COUNT) begin
			fin_res.remaining_ticks = cyc_left;
			fin_res.expiry_count    = dv_quo_q + CNT_W'(1);
			fin_wd                  = {cyc_left, rd_cyc};
		end else begin
			fin_res.remaining_ticks = abs_d;
			fin_res.expiry_count    = '0;
			fin_wd                  = {abs_d, cyc_q};
		end
	end

	assign mem_we = ((state_q == S_EVAL) && ev_we) || (state_q == S_FIN);
	assign mem_wd = (state_q == S_FIN) ? fin_wd : ev_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[idx_q] <= mem_wd;
		end
		if (req_take) begin
			rd_q <= tbl_mem[req.alarm_id[IdxW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '1;
			min_q <= FIELD_W'(1);
			ext_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_ALLOWED: max_q <= cfg_data;
				CFG_MIN_CYCLE:   min_q <= cfg_data;
				CFG_EXT_CHECK:   ext_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			run_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != S_OUT)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						type_q  <= req.req_type;
						amt_q   <= req.amount & CutMask;
						cyc_q   <= req.cycle & CutMask;
						now_q   <= req.counter_now & CutMask;
						idx_q   <= req.alarm_id[IdxW-1:0];
						id_ok_q <= ({1'b0, req.alarm_id} < NumAlarms);
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_q <= ev_res;
					if (ev_set) begin
						run_q[idx_q] <= 1'b1;
					end
					if (ev_clr) begin
						run_q[idx_q] <= 1'b0;
					end
					if (ev_go_div) begin
						div_op_q <= ev_op;
						dv_rem_q <= '0;
						dv_quo_q <= ev_dvd;
						dv_dvs_q <= ev_dvs;
						step_q   <= '0;
						state_q  <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if ((step_q == LastStep) && (div_op_q == DIV_MOD_START)) begin
						s_mod_q  <= dv_rem_nx;
						div_op_q <= DIV_MOD_NOW;
						dv_rem_q <= '0;
						dv_quo_q <= {1'b0, now_q};
						step_q   <= '0;
					end else begin
						dv_rem_q <= dv_rem_nx;
						dv_quo_q <= {dv_quo_q[REM_W-2:0], dv_bit};
						step_q   <= step_q + StepW'(1);
						if (step_q == LastStep) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					res_q        <= fin_res;
					run_q[idx_q] <= 1'b1;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/cat_checker.sv
// port checks for the cyclic alarm table and their binding
module cat_checker
	import cat_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input cat_res_t rsp
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	a_bad_id_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_BAD_ID) |->
		(rsp.remaining_ticks == '0) && (rsp.expiry_count == '0) && !rsp.alarm_running)
		else $error("bad id beat carries alarm data");

	a_stopped_no_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.alarm_running |-> (rsp.remaining_ticks == '0))
		else $error("stopped alarm reports ticks");

	a_expiry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.expiry_count != '0) |-> (rsp.status == ST_OK))
		else $error("expiry reported on a failed request");

endmodule

bind cyclic_alarm_table_core cat_checker u_cat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
